[hw/rtl/mpfl_pkg.sv]
// ----------------------------------------------------------------------------
// mpfl_pkg
// Shared constants, codes and types of the multi-pool free-list allocator.
// ----------------------------------------------------------------------------
package mpfl_pkg;

  localparam int NUM_POOLS   = 4;
  localparam int MAX_ENTRIES = 64;
  localparam int TAG_WIDTH   = 32;

  localparam int POOL_W    = 2;
  localparam int ENTRY_W   = 6;
  localparam int CNT_W     = 7;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_REGS  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_RESET = 64;

  localparam int MEM_DEPTH = NUM_POOLS * MAX_ENTRIES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_SET_TAG = 3'd3,
    OP_GET_TAG = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]   handle;
    logic [TAG_WIDTH-1:0] tag_out;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     free_left;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [MEM_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [MEM_AW-1:0]  raddr;
  } ring_req_t;

  typedef struct packed {
    logic                 we;
    logic [MEM_AW-1:0]    waddr;
    logic [TAG_WIDTH-1:0] wdata;
    logic                 re;
    logic [MEM_AW-1:0]    raddr;
  } tag_req_t;

endpackage

[hw/rtl/mpfl_in_if.sv]
// ----------------------------------------------------------------------------
// mpfl_in_if
// Command channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface mpfl_in_if
  import mpfl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [POOL_W-1:0]    pool;
  logic [ENTRY_W-1:0]   entry;
  logic [TAG_WIDTH-1:0] tag_value;

  modport source (output valid, opcode, pool, entry, tag_value, input ready);
  modport sink   (input valid, opcode, pool, entry, tag_value, output ready);
endinterface

[hw/rtl/mpfl_out_if.sv]
// ----------------------------------------------------------------------------
// mpfl_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface mpfl_out_if
  import mpfl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ENTRY_W-1:0]   handle;
  logic [TAG_WIDTH-1:0] tag_out;
  logic [STATUS_W-1:0]  status;
  logic [CNT_W-1:0]     free_left;

  modport source (output valid, handle, tag_out, status, free_left, input ready);
  modport sink   (input valid, handle, tag_out, status, free_left, output ready);
endinterface

[hw/rtl/multi_pool_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// multi_pool_free_list_allocator_top
// Multi-pool free-list allocator: ring and tag memories, sequencer and
// result output register.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          opcode, pool, entry, tag_value
//   out_ch    out  valid/ready          handle, tag_out, status, free_left
//   cfg       in   cfg_we (no wait)     cfg_index, cfg_wdata
//
// A successful alloc or get tag does one ring or tag memory read; its result
// comes from S_READ. Other operations finish in the transfer cycle.
// Init adds a sweep of NUM_POOLS*MAX_ENTRIES (256) ring words, no transfer.
// No input transfer while the output register is full and not drained.
// Reset clears counters, fronts and tag valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module multi_pool_free_list_allocator_top
  import mpfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mpfl_in_if.sink              in_ch,
  mpfl_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ring_req_t            ring_req;
  tag_req_t             tag_req;
  logic [ENTRY_W-1:0]   ring_rdata;
  logic [TAG_WIDTH-1:0] tag_rdata;
  logic                 out_free;
  logic                 res_load;
  res_t                 res;
  logic                 out_valid_r;
  res_t                 out_res_r;

  mpfl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .re    (ring_req.re),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  mpfl_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_tag (
    .clk   (clk),
    .we    (tag_req.we),
    .waddr (tag_req.waddr),
    .wdata (tag_req.wdata),
    .re    (tag_req.re),
    .raddr (tag_req.raddr),
    .rdata (tag_rdata)
  );

  mpfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata),
    .tag_req    (tag_req),
    .tag_rdata  (tag_rdata),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.handle    = out_res_r.handle;
  assign out_ch.tag_out   = out_res_r.tag_out;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.free_left = out_res_r.free_left;

endmodule

[hw/rtl/mpfl_ram.sv]
// ----------------------------------------------------------------------------
// mpfl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mpfl_ctrl.sv]
// ----------------------------------------------------------------------------
// mpfl_ctrl
// Sequencer: pool counters, ring fronts, tag valid bits, ring init sweep
// and the read-modify-write control of the ring and tag memories.
// ----------------------------------------------------------------------------
module mpfl_ctrl
  import mpfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mpfl_in_if.sink              in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output ring_req_t            ring_req,
  input  logic [ENTRY_W-1:0]   ring_rdata,
  output tag_req_t             tag_req,
  input  logic [TAG_WIDTH-1:0] tag_rdata,
  input  logic                 out_free,
  output logic                 res_load,
  output res_t                 res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_INIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   size_r     [CFG_REGS];
  logic [CFG_W-1:0]   size_nxt   [CFG_REGS];
  logic [ENTRY_W-1:0] front_r    [NUM_POOLS];
  logic [ENTRY_W-1:0] front_nxt  [NUM_POOLS];
  logic [CNT_W-1:0]   count_r    [NUM_POOLS];
  logic [CNT_W-1:0]   count_nxt  [NUM_POOLS];
  logic [MEM_DEPTH-1:0] tag_vld_r, tag_vld_nxt;
  logic [MEM_AW-1:0]  sweep_r, sweep_nxt;
  logic               pend_alloc_r, pend_alloc_nxt;
  logic [MEM_AW-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]   pend_fl_r, pend_fl_nxt;

  logic               accept;
  logic               pool_ok;
  logic [CNT_W-1:0]   n_sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic [ENTRY_W-1:0] frt_sel;
  logic [CNT_W:0]     back_sum;
  logic [ENTRY_W-1:0] back_idx;
  logic [ENTRY_W-1:0] new_front;
  logic [MEM_AW-1:0]  entry_addr;

  function automatic logic [CNT_W-1:0] pool_size(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (CNT_W'(v) > CNT_W'(MAX_ENTRIES)) begin
      r = CNT_W'(MAX_ENTRIES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pool_ok     = (32'(in_ch.pool) < NUM_POOLS);
  assign n_sel       = pool_size(size_r[in_ch.pool]);
  assign cnt_sel     = count_r[in_ch.pool];
  assign frt_sel     = front_r[in_ch.pool];
  assign entry_addr  = {in_ch.pool, in_ch.entry};

  always_comb begin
    back_sum = (CNT_W + 1)'(frt_sel) + (CNT_W + 1)'(cnt_sel) - (CNT_W + 1)'(1);
    if (back_sum >= (CNT_W + 1)'(MAX_ENTRIES)) begin
      back_idx = ENTRY_W'(back_sum - (CNT_W + 1)'(MAX_ENTRIES));
    end else begin
      back_idx = ENTRY_W'(back_sum);
    end
    if (frt_sel == '0) begin
      new_front = ENTRY_W'(MAX_ENTRIES - 1);
    end else begin
      new_front = frt_sel - ENTRY_W'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    tag_vld_nxt    = tag_vld_r;
    sweep_nxt      = sweep_r;
    pend_alloc_nxt = pend_alloc_r;
    pend_addr_nxt  = pend_addr_r;
    pend_fl_nxt    = pend_fl_r;
    ring_req       = '0;
    tag_req        = '0;
    res_load       = 1'b0;
    res            = '0;

    if (cfg_we && (32'(cfg_index) < CFG_REGS)) begin
      size_nxt[cfg_index] = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res.free_left = pool_ok ? cnt_sel : '0;
          res.status    = STS_OK;
          res_load      = 1'b1;
          if (in_ch.opcode == OP_INIT) begin
            for (int q = 0; q < NUM_POOLS; q++) begin
              if (q < CFG_REGS) begin
                count_nxt[q] = pool_size(size_r[q]);
              end else begin
                count_nxt[q] = CNT_W'(MAX_ENTRIES);
              end
              front_nxt[q] = '0;
            end
            tag_vld_nxt   = '0;
            sweep_nxt     = '0;
            state_nxt     = S_INIT;
            res.free_left = pool_ok ? n_sel : '0;
            res.status    = pool_ok ? STS_OK : STS_RANGE;
          end else if (!pool_ok) begin
            if (in_ch.opcode inside {OP_ALLOC, OP_FREE, OP_SET_TAG, OP_GET_TAG}) begin
              res.status = STS_RANGE;
            end
          end else begin
            case (in_ch.opcode)
              OP_ALLOC: begin
                if (cnt_sel == '0) begin
                  res.status = STS_EMPTY;
                end else begin
                  ring_req.re              = 1'b1;
                  ring_req.raddr           = {in_ch.pool, back_idx};
                  count_nxt[in_ch.pool]    = cnt_sel - CNT_W'(1);
                  pend_alloc_nxt           = 1'b1;
                  pend_fl_nxt              = cnt_sel - CNT_W'(1);
                  res_load                 = 1'b0;
                  state_nxt                = S_READ;
                end
              end
              OP_FREE: begin
                if (CNT_W'(in_ch.entry) >= n_sel) begin
                  res.status = STS_RANGE;
                end else if (cnt_sel >= n_sel) begin
                  res.status = STS_FULL;
                end else begin
                  tag_vld_nxt[entry_addr] = 1'b0;
                  front_nxt[in_ch.pool]   = new_front;
                  count_nxt[in_ch.pool]   = cnt_sel + CNT_W'(1);
                  ring_req.we             = 1'b1;
                  ring_req.waddr          = {in_ch.pool, new_front};
                  ring_req.wdata          = in_ch.entry;
                  res.free_left           = cnt_sel + CNT_W'(1);
                end
              end
              OP_SET_TAG: begin
                if (CNT_W'(in_ch.entry) >= n_sel) begin
                  res.status = STS_RANGE;
                end else begin
                  tag_vld_nxt[entry_addr] = 1'b1;
                  tag_req.we              = 1'b1;
                  tag_req.waddr           = entry_addr;
                  tag_req.wdata           = in_ch.tag_value;
                end
              end
              OP_GET_TAG: begin
                if (CNT_W'(in_ch.entry) >= n_sel) begin
                  res.status = STS_RANGE;
                end else begin
                  tag_req.re     = 1'b1;
                  tag_req.raddr  = entry_addr;
                  pend_alloc_nxt = 1'b0;
                  pend_addr_nxt  = entry_addr;
                  pend_fl_nxt    = cnt_sel;
                  res_load       = 1'b0;
                  state_nxt      = S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.status    = STS_OK;
          res.free_left = pend_fl_r;
          if (pend_alloc_r) begin
            res.handle = ring_rdata;
          end else if (tag_vld_r[pend_addr_r]) begin
            res.tag_out = tag_rdata;
          end
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        ring_req.we    = 1'b1;
        ring_req.waddr = sweep_r;
        ring_req.wdata = sweep_r[ENTRY_W-1:0];
        sweep_nxt      = sweep_r + MEM_AW'(1);
        if (sweep_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      for (int i = 0; i < CFG_REGS; i++) begin
        size_r[i] <= CFG_W'(CFG_RESET);
      end
      for (int q = 0; q < NUM_POOLS; q++) begin
        front_r[q] <= '0;
        count_r[q] <= '0;
      end
      tag_vld_r    <= '0;
      sweep_r      <= '0;
      pend_alloc_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      size_r       <= size_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      tag_vld_r    <= tag_vld_nxt;
      sweep_r      <= sweep_nxt;
      pend_alloc_r <= pend_alloc_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    pend_fl_r   <= pend_fl_nxt;
  end

`ifndef SYNTHESIS
  a_ring_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_req.we && ring_req.re))
    else $error("ring read and write in the same cycle");

  a_tag_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(tag_req.we && tag_req.re))
    else $error("tag read and write in the same cycle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded into a full output register");

  a_init_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.opcode == OP_INIT) |=> (state_r == S_INIT && !in_ch.ready))
    else $error("init transfer did not start the ring sweep");

  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_req.re || tag_req.re) |=> (state_r == S_READ))
    else $error("memory read issued outside a read operation");
`endif

endmodule

[tb/tb_multi_pool_free_list_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_pool_free_list_allocator_top
// Self-checking bench for the multi-pool free-list allocator. A driver feeds
// commands and pool-size register writes from a queue. A shadow copy of the
// free rings, fronts, counts and tags predicts every response. A monitor
// checks each response transfer against the oldest prediction. Random gaps
// are applied on the command channel and back-pressure on the response channel.
// ----------------------------------------------------------------------------
module tb_multi_pool_free_list_allocator_top;
  import mpfl_pkg::*;

  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 12;
  localparam int PHASE_OPS      = 150;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_3 = 2'd3;

  typedef enum {JOB_OP, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t              kind;
    logic [OP_W-1:0]        opcode;
    logic [POOL_W-1:0]      pool;
    logic [ENTRY_W-1:0]     entry;
    logic [TAG_WIDTH-1:0]   tag_value;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
  } job_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  mpfl_in_if  cmd_if ();
  mpfl_out_if rsp_if ();

  multi_pool_free_list_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_if),
    .out_ch    (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow allocator state
  logic [ENTRY_W-1:0]   ring_copy  [NUM_POOLS][MAX_ENTRIES];
  logic [TAG_WIDTH-1:0] tag_copy   [NUM_POOLS][MAX_ENTRIES];
  int                   front_copy [NUM_POOLS];
  int                   left_copy  [NUM_POOLS];
  logic [CFG_W-1:0]     pool_cfg   [CFG_REGS];

  job_t cmd_queue[$];
  res_t awaited_results[$];

  logic cmd_taken;
  int   idle_cycles;
  int   mismatches;
  int   send_gap, send_quiet, settle;
  int   rsp_hold, rsp_quiet;
  int   gen_size [CFG_REGS];

  function automatic int pool_limit(int q);
    return (pool_cfg[q] > MAX_ENTRIES) ? MAX_ENTRIES : int'(pool_cfg[q]);
  endfunction

  function automatic res_t predict_pool_op(logic [OP_W-1:0] op, logic [POOL_W-1:0] p,
                                           logic [ENTRY_W-1:0] e,
                                           logic [TAG_WIDTH-1:0] tv);
    res_t r;
    int   n;
    int   back;
    r = '0;
    case (op)
      OP_INIT: begin
        for (int q = 0; q < NUM_POOLS; q++) begin
          n = pool_limit(q);
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            tag_copy[q][j] = '0;
            if (j < n) ring_copy[q][j] = ENTRY_W'(j);
          end
          front_copy[q] = 0;
          left_copy[q]  = n;
        end
      end
      OP_ALLOC: begin
        if (left_copy[p] == 0) begin
          r.status = STS_EMPTY;
        end else begin
          back = (front_copy[p] + left_copy[p] - 1) % MAX_ENTRIES;
          r.handle = ring_copy[p][back];
          left_copy[p]--;
        end
      end
      OP_FREE, OP_SET_TAG, OP_GET_TAG: begin
        n = pool_limit(p);
        if (int'(e) >= n) begin
          r.status = STS_RANGE;
        end else if (op == OP_FREE) begin
          if (left_copy[p] >= n) begin
            r.status = STS_FULL;
          end else begin
            tag_copy[p][e] = '0;
            front_copy[p] = (front_copy[p] + MAX_ENTRIES - 1) % MAX_ENTRIES;
            ring_copy[p][front_copy[p]] = e;
            left_copy[p]++;
          end
        end else if (op == OP_SET_TAG) begin
          tag_copy[p][e] = tv;
        end else begin
          r.tag_out = tag_copy[p][e];
        end
      end
      default: ;
    endcase
    r.free_left = CNT_W'(left_copy[p]);
    return r;
  endfunction

  function automatic int pick_pause(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_op(logic [OP_W-1:0] op, logic [POOL_W-1:0] p,
                        logic [ENTRY_W-1:0] e, logic [TAG_WIDTH-1:0] tv);
    job_t j;
    j = '{kind: JOB_OP, opcode: op, pool: p, entry: e, tag_value: tv,
          reg_idx: '0, reg_val: '0};
    cmd_queue.push_back(j);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    job_t j;
    j = '{kind: JOB_CFG, opcode: '0, pool: '0, entry: '0, tag_value: '0,
          reg_idx: idx, reg_val: val};
    cmd_queue.push_back(j);
    gen_size[idx] = (val > MAX_ENTRIES) ? MAX_ENTRIES : int'(val);
  endtask

  task automatic add_drain();
    job_t j;
    j = '{kind: JOB_DRAIN, opcode: '0, pool: '0, entry: '0, tag_value: '0,
          reg_idx: '0, reg_val: '0};
    cmd_queue.push_back(j);
  endtask

  task automatic report_result(string why, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp handle=%0d tag=%h status=%0d left=%0d", $realtime, why,
               want.handle, want.tag_out, want.status, want.free_left,
               " | got handle=%0d tag=%h status=%0d left=%0d",
               got.handle, got.tag_out, got.status, got.free_left);
  endtask

  // command driver
  always @(negedge clk) begin : feed_commands
    logic vld_n;
    logic we_n;
    job_t head;
    vld_n = cmd_if.valid && !cmd_taken;
    we_n  = 1'b0;
    if (!rst_n) begin
      vld_n = 1'b0;
    end else if (!vld_n) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (cmd_queue.size() > 0) begin
        head = cmd_queue[0];
        case (head.kind)
          JOB_OP: begin
            void'(cmd_queue.pop_front());
            cmd_if.opcode    <= head.opcode;
            cmd_if.pool      <= head.pool;
            cmd_if.entry     <= head.entry;
            cmd_if.tag_value <= head.tag_value;
            vld_n    = 1'b1;
            send_gap = pick_pause(send_quiet);
            settle   = 0;
          end
          JOB_DRAIN: begin
            if (awaited_results.size() == 0) void'(cmd_queue.pop_front());
          end
          JOB_CFG: begin
            // let an init ring sweep finish before touching pool sizes
            if (awaited_results.size() == 0) begin
              if (settle < SETTLE_CYCLES) begin
                settle++;
              end else begin
                void'(cmd_queue.pop_front());
                cfg_index <= head.reg_idx;
                cfg_wdata <= head.reg_val;
                we_n = 1'b1;
              end
            end
          end
          default: begin
            void'(cmd_queue.pop_front());
          end
        endcase
      end
    end
    cmd_if.valid <= vld_n;
    cfg_we       <= we_n;
  end

  // response back-pressure
  always @(negedge clk) begin : pace_responses
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_hold = pick_pause(rsp_quiet);
    end
  end

  // monitor: check responses, then predict newly accepted commands
  always @(posedge clk) begin : watch_channels
    res_t got;
    res_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{handle: rsp_if.handle, tag_out: rsp_if.tag_out,
                status: rsp_if.status, free_left: rsp_if.free_left};
        if (awaited_results.size() == 0) begin
          report_result("unexpected response", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.handle !== want.handle || got.tag_out !== want.tag_out ||
              got.status !== want.status || got.free_left !== want.free_left)
            report_result("response mismatch", want, got);
        end
      end
      if (cfg_we) pool_cfg[cfg_index] = cfg_wdata;
      if (cmd_if.valid && cmd_if.ready)
        awaited_results.push_back(predict_pool_op(cmd_if.opcode, cmd_if.pool,
                                                  cmd_if.entry, cmd_if.tag_value));
    end
    cmd_taken <= rst_n && cmd_if.valid && cmd_if.ready;
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int  r, p, sz, drain_at;
    logic [OP_W-1:0]    op;
    logic [ENTRY_W-1:0] e;

    rst_n            = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.opcode    = '0;
    cmd_if.pool      = '0;
    cmd_if.entry     = '0;
    cmd_if.tag_value = '0;
    rsp_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    cmd_taken        = 1'b0;
    idle_cycles      = 0;
    mismatches       = 0;
    send_gap = 0; send_quiet = 0; settle = 0;
    rsp_hold = 0; rsp_quiet = 0;
    for (int q = 0; q < NUM_POOLS; q++) begin
      front_copy[q] = 0;
      left_copy[q]  = 0;
      pool_cfg[q]   = CFG_RESET;
      gen_size[q]   = CFG_RESET;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        ring_copy[q][j] = '0;
        tag_copy[q][j]  = '0;
      end
    end

    // directed: one-entry, full-size, zero-size and capped pools
    add_cfg(REG_POOL_0, 7'd1);
    add_cfg(REG_POOL_1, 7'd64);
    add_cfg(REG_POOL_2, 7'd0);
    add_cfg(REG_POOL_3, 7'd100);
    add_op(OP_ALLOC,   0, 0, 0);            // pools empty before init
    add_op(OP_GET_TAG, 1, 0, 0);
    add_op(OP_INIT,    2, 0, 0);
    add_op(OP_ALLOC,   0, 0, 0);
    add_op(OP_ALLOC,   0, 0, 0);            // empty
    add_op(OP_FREE,    0, 1, 0);            // out of range
    add_op(OP_FREE,    0, 0, 0);
    add_op(OP_FREE,    0, 0, 0);            // over-full
    add_op(OP_SET_TAG, 1, 63, 32'hFFFF_FFFF);
    add_op(OP_FREE,    1, 63, 0);           // over-full keeps tag
    add_op(OP_GET_TAG, 1, 63, 0);
    add_op(OP_ALLOC,   1, 0, 0);
    add_op(OP_ALLOC,   1, 0, 0);
    add_op(OP_FREE,    1, 63, 0);
    add_op(OP_FREE,    1, 63, 0);           // double free
    add_op(OP_GET_TAG, 1, 63, 0);
    add_op(OP_SET_TAG, 2, 0, 32'h0000_0001); // zero-size pool
    add_op(OP_ALLOC,   2, 0, 0);
    add_op(OP_FREE,    2, 0, 0);
    add_op(OP_SET_TAG, 3, 63, 32'hA5A5_5A5A);
    add_op(OP_GET_TAG, 3, 63, 0);
    add_op(OP_UNUSED_LO, 1, 63, 32'hFFFF_FFFF);
    add_op(OP_UNUSED_HI, 3, 0, 0);
    add_drain();
    // resize after init: ring left as is, checks use new size
    add_cfg(REG_POOL_1, 7'd2);
    add_cfg(REG_POOL_3, 7'd127);
    add_op(OP_FREE,  1, 5, 0);
    add_op(OP_ALLOC, 1, 0, 0);
    add_op(OP_FREE,  1, 1, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int q = 0; q < CFG_REGS; q++) begin
        if ($urandom_range(0, 2) != 0) begin
          r = $urandom_range(0, 99);
          if (r < 8)       sz = 0;
          else if (r < 18) sz = 1;
          else if (r < 28) sz = MAX_ENTRIES;
          else if (r < 33) sz = $urandom_range(MAX_ENTRIES + 1, 127);
          else if (r < 80) sz = $urandom_range(2, 12);
          else             sz = $urandom_range(13, MAX_ENTRIES - 1);
          add_cfg(CFG_IDX_W'(q), CFG_W'(sz));
        end
      end
      if ($urandom_range(0, 3) != 0) add_op(OP_INIT, POOL_W'($urandom_range(0, 3)), 0, 0);
      drain_at = $urandom_range(20, PHASE_OPS - 20);
      for (int i = 0; i < PHASE_OPS; i++) begin
        if (i == drain_at) add_drain();
        r = $urandom_range(0, 99);
        if (r < 38)      op = OP_ALLOC;
        else if (r < 68) op = OP_FREE;
        else if (r < 80) op = OP_SET_TAG;
        else if (r < 92) op = OP_GET_TAG;
        else if (r < 95) op = OP_INIT;
        else             op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        p = $urandom_range(0, NUM_POOLS - 1);
        if (gen_size[p] > 0 && $urandom_range(0, 9) != 0)
          e = ENTRY_W'($urandom_range(0, gen_size[p] - 1));
        else
          e = ENTRY_W'($urandom_range(0, MAX_ENTRIES - 1));
        add_op(op, POOL_W'(p), e, $urandom());
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || cmd_if.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
